@@ rtl/nps_pkg.sv @@
// Shared types and constants for the nearest waypoint search block.
package nps_pkg;

   // Table size and derived widths.
   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CFG_W      = 9;
   localparam int COORD_W    = 16;
   localparam int SHIFT      = 6;
   localparam int Q_W        = COORD_W - SHIFT;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DIST_W     = DIFF_W + 1;
   localparam int SLOT_W     = 8;
   localparam int OUT_IDX_W  = 8;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic                       req_type;
      logic [SLOT_W-1:0]          slot;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_z;
      logic signed [COORD_W-1:0]  coord_y;
   } req_item_type;

   // One result.
   typedef struct packed {
      logic [OUT_IDX_W-1:0] nearest_index;
      logic                 found;
   } rsp_item_type;

   // One stored waypoint.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
   } point_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_point;
      logic start_query;
      logic issue;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic last_issue;
      logic last_cmp;
   } status_type;

endpackage

@@ rtl/nps_ctrl.sv @@
// Controller state machine for the nearest waypoint search.
module nps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_kind,
   input  nps_pkg::status_type  status,
   output nps_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import nps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // A request is taken whenever the block is not busy.
   assign accept = start && !busy_ff;

   // Command decode.
   always_comb begin
      cmd.write_point = accept && (req_kind == REQ_LOAD);
      cmd.start_query = accept && (req_kind == REQ_QUERY);
      cmd.issue       = (state_ff == ST_SCAN);
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff) inside
            ST_IDLE, ST_REPLY: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
               if (cmd.start_query) begin
                  if (status.count_zero) begin
                     // Nothing to scan: answer at once.
                     state_ff     <= ST_REPLY;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_SCAN;
                     busy_ff  <= 1'b1;
                  end
               end
            end
            ST_SCAN: begin
               if (status.last_issue) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // Wait for the last entry to leave the compare stage.
               if (status.last_cmp) begin
                  state_ff     <= ST_REPLY;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/nps_datapath.sv @@
// Datapath: waypoint memory, distance pipeline and running minimum.
module nps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  nps_pkg::req_item_type  req_data,
   input  logic                   csr_valid,
   input  logic [nps_pkg::CFG_W-1:0] csr_data,
   input  nps_pkg::cmd_type       cmd,
   output nps_pkg::status_type    status,
   output nps_pkg::rsp_item_type  rsp_data
);
   import nps_pkg::*;

   // Waypoint memory, one write and one registered read port.
   point_type mem [MAX_POINTS];

   logic [CFG_W-1:0]       count_ff;
   logic [IDX_W-1:0]       last_idx_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic signed [Q_W-1:0]  qx_ff;
   logic signed [Q_W-1:0]  qz_ff;
   logic signed [Q_W-1:0]  qy_ff;
   int                     last_idx_in;

   // Read stage.
   point_type              rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_last_ff;
   logic [IDX_W-1:0]       rd_idx_ff;

   // Absolute difference stage.
   logic [DIFF_W-1:0]      ad_x_ff;
   logic [DIFF_W-1:0]      ad_z_ff;
   logic [DIFF_W-1:0]      ad_y_ff;
   logic                   ad_valid_ff;
   logic                   ad_last_ff;
   logic [IDX_W-1:0]       ad_idx_ff;

   // Sum stage.
   logic [DIST_W-1:0]      dist_ff;
   logic                   ds_valid_ff;
   logic                   ds_last_ff;
   logic [IDX_W-1:0]       ds_idx_ff;

   // Running minimum.
   logic [DIST_W-1:0]      best_dist_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic                   found_ff;

   logic signed [DIFF_W-1:0] px;
   logic signed [DIFF_W-1:0] pz;
   logic signed [DIFF_W-1:0] py;
   logic signed [DIFF_W-1:0] qx;
   logic signed [DIFF_W-1:0] qz;
   logic signed [DIFF_W-1:0] qy;
   logic                     take;

   // Last index to scan, with the count held to the table size.
   always_comb begin
      if (32'(count_ff) > MAX_POINTS) begin
         last_idx_in = MAX_POINTS - 1;
      end else begin
         last_idx_in = 32'(count_ff) - 1;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.last_issue = (addr_ff == last_idx_ff);
   assign status.last_cmp   = ds_valid_ff && ds_last_ff;

   // Memory write and read.
   always_ff @(posedge clock) begin
      if (cmd.write_point && (32'(req_data.slot) < MAX_POINTS)) begin
         mem[IDX_W'(req_data.slot)] <= '{x: req_data.coord_x,
                                         z: req_data.coord_z,
                                         y: req_data.coord_y};
      end
      rd_data_ff <= mem[addr_ff];
   end

   // Sign-extended operands for the differences.
   assign px = DIFF_W'(rd_data_ff.x);
   assign pz = DIFF_W'(rd_data_ff.z);
   assign py = DIFF_W'(rd_data_ff.y);
   assign qx = DIFF_W'(qx_ff);
   assign qz = DIFF_W'(qz_ff);
   assign qy = DIFF_W'(qy_ff);

   // A new entry wins only when strictly closer, so the lowest index keeps ties.
   assign take = ds_valid_ff && (!found_ff || (dist_ff < best_dist_ff));

   // Query setup, address counter and the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
         ad_valid_ff <= 1'b0;
         ds_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         best_idx_ff <= '0;
         addr_ff     <= '0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_data;
         end

         // Query setup: scale the position and clear the running minimum.
         if (cmd.start_query) begin
            qx_ff       <= Q_W'(req_data.coord_x >>> SHIFT);
            qz_ff       <= Q_W'(req_data.coord_z >>> SHIFT);
            qy_ff       <= Q_W'(req_data.coord_y >>> SHIFT);
            last_idx_ff <= IDX_W'(last_idx_in);
            addr_ff     <= '0;
            found_ff    <= 1'b0;
            best_idx_ff <= '0;
         end else if (cmd.issue) begin
            addr_ff <= addr_ff + 1'b1;
         end

         // Read stage tags.
         rd_valid_ff <= cmd.issue;
         rd_last_ff  <= cmd.issue && status.last_issue;
         rd_idx_ff   <= addr_ff;

         // Absolute differences per axis.
         ad_x_ff     <= (px > qx) ? DIFF_W'(px - qx) : DIFF_W'(qx - px);
         ad_z_ff     <= (pz > qz) ? DIFF_W'(pz - qz) : DIFF_W'(qz - pz);
         ad_y_ff     <= (py > qy) ? DIFF_W'(py - qy) : DIFF_W'(qy - py);
         ad_valid_ff <= rd_valid_ff;
         ad_last_ff  <= rd_last_ff;
         ad_idx_ff   <= rd_idx_ff;

         // Manhattan distance.
         dist_ff     <= DIST_W'(ad_x_ff) + DIST_W'(ad_z_ff) + DIST_W'(ad_y_ff);
         ds_valid_ff <= ad_valid_ff;
         ds_last_ff  <= ad_last_ff;
         ds_idx_ff   <= ad_idx_ff;

         // Running minimum.
         if (take) begin
            found_ff     <= 1'b1;
            best_dist_ff <= dist_ff;
            best_idx_ff  <= ds_idx_ff;
         end
      end
   end

   assign rsp_data.nearest_index = OUT_IDX_W'(best_idx_ff);
   assign rsp_data.found         = found_ff;

endmodule

@@ rtl/nearest_point_manhattan_search.sv @@
// Top level of the nearest waypoint search by Manhattan distance.
//
//   Channel   Ports                        Moves
//   request   start, busy, req_data        load of one waypoint or a query
//   result    rsp_valid, rsp_data          nearest index and found flag
//   config    csr_valid, csr_ready, csr_data   waypoint count
//
// A load request leaves busy low. A query over n waypoints holds busy while
// its entries are read and drained through the pipeline and strobes its result
// as busy falls; the single memory read port takes one entry a cycle. A query
// with a count of zero strobes in the next cycle.
// Reset is synchronous and clears the count; the waypoint memory is not cleared.
// The result is strobed for one cycle and cannot be stalled.
module nearest_point_manhattan_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  nps_pkg::req_item_type      req_data,
   output logic                       rsp_valid,
   output nps_pkg::rsp_item_type      rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [nps_pkg::CFG_W-1:0]  csr_data
);
   import nps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The count register takes a write in any cycle.
   assign csr_ready = 1'b1;

   nps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_data.req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   nps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/nps_checker.sv @@
// Port-level checks for the nearest waypoint search, bound to the top level.
module nps_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input nps_pkg::req_item_type      req_data,
   input logic                       rsp_valid,
   input nps_pkg::rsp_item_type      rsp_data
);
   import nps_pkg::*;

   // A result is never shown while a scan is still running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   // An accepted query either starts a scan or answers at once.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == REQ_QUERY) |=> (busy || rsp_valid))
      else $error("query request accepted but neither scanned nor answered");

   // A load request gives no result and leaves the block free.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == REQ_LOAD) |=> (!rsp_valid && !busy))
      else $error("load request produced a result or a busy cycle");

   // An empty scan reports index zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.nearest_index == '0))
      else $error("nonzero index reported without a waypoint found");

   // Busy only rises after a request is presented.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

endmodule

bind nearest_point_manhattan_search nps_checker u_nps_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
